FILE: hw/rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude core.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int MAX_WIDTH_DEF = 2048;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;

	// configuration register indexes
	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

	// gradient queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [10:0] gx;
		logic signed [10:0] gy;
		logic [10:0]        col;
		logic [15:0]        row;
		logic               last;
	} grad_item_t;

endpackage

FILE: hw/rtl/sem_front.sv
// ----------------------------------------------------------------------------
// sem_front
// Pixel intake: position counters, two line stores, 3x3 window and Sobel
// gradients. Pushes one gradient item per interior pixel into the queue.
// ----------------------------------------------------------------------------
module sem_front #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [0:0]                   cfg_index,
	input  logic [15:0]                  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   pixel,
	input  logic [sem_pkg::QLEVEL_W-1:0] q_level,
	output logic                         push_valid,
	output sem_pkg::grad_item_t          push_item
);
	import sem_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int QW1 = QLEVEL_W + 1;

	logic [11:0]   width_q;
	logic [15:0]   height_q;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;

	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	logic [WW-1:0] col_ext;
	logic          emit_now;
	logic          last_now;
	logic          accept;
	logic [QW1-1:0] committed;

	logic [7:0] upper_mem  [MAX_WIDTH];
	logic [7:0] middle_mem [MAX_WIDTH];

	logic          valid_s1;
	logic          emit_s1;
	logic [7:0]    pix_s1;
	logic [CW-1:0] addr_s1;
	logic [7:0]    top_s1;
	logic [7:0]    mid_s1;
	logic [10:0]   col_s1;
	logic [15:0]   row_s1;
	logic          last_s1;

	logic        emit_s2;
	logic [10:0] col_s2;
	logic [15:0] row_s2;
	logic        last_s2;

	logic [7:0] win_q [3][3];

	logic [9:0] gx_pos, gx_neg, gy_pos, gy_neg;

	// effective frame size
	always_comb begin
		if (width_q < 12'd3) begin
			w_eff = WW'(3);
		end else if ({20'd0, width_q} > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q < 16'd3) ? 16'd3 : height_q;
	end

	assign col_ext  = WW'(col_q);
	assign emit_now = (col_ext >= WW'(2)) && (col_ext < w_eff)
		&& (row_q >= 16'd2) && (row_q < h_eff);
	assign last_now = (col_ext == w_eff - WW'(1)) && (row_q == h_eff - 16'd1);

	// room for every item already on its way to the queue
	assign committed = QW1'(q_level) + QW1'(emit_s1) + QW1'(emit_s2);
	assign s_tready  = !emit_now || (committed < QW1'(QUEUE_DEPTH));
	assign accept    = s_tvalid && s_tready;

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data[11:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
				endcase
			end
			if (accept) begin
				if (col_ext + WW'(1) >= w_eff) begin
					col_q <= '0;
					if (17'(row_q) + 17'd1 >= 17'(h_eff)) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + 16'd1;
					end
				end else begin
					col_q <= CW'(col_ext + WW'(1));
				end
			end
		end
	end

	// line stores
	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1 <= upper_mem[col_q];
			mid_s1 <= middle_mem[col_q];
		end
		if (valid_s1) begin
			upper_mem[addr_s1]  <= mid_s1;
			middle_mem[addr_s1] <= pix_s1;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			emit_s2  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			emit_s1  <= accept && emit_now;
			emit_s2  <= emit_s1;
		end
	end

	// pipeline payload and window
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			addr_s1 <= col_q;
			col_s1  <= 11'(col_ext - WW'(1));
			row_s1  <= row_q - 16'd1;
			last_s1 <= last_now;
		end
		if (valid_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= top_s1;
			win_q[1][2] <= mid_s1;
			win_q[2][2] <= pix_s1;
		end
		col_s2  <= col_s1;
		row_s2  <= row_s1;
		last_s2 <= last_s1;
	end

	// sobel gradients on the completed window
	always_comb begin
		gx_pos = 10'(win_q[0][2]) + {1'b0, win_q[1][2], 1'b0} + 10'(win_q[2][2]);
		gx_neg = 10'(win_q[0][0]) + {1'b0, win_q[1][0], 1'b0} + 10'(win_q[2][0]);
		gy_pos = 10'(win_q[2][0]) + {1'b0, win_q[2][1], 1'b0} + 10'(win_q[2][2]);
		gy_neg = 10'(win_q[0][0]) + {1'b0, win_q[0][1], 1'b0} + 10'(win_q[0][2]);
		push_item.gx   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
		push_item.gy   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
		push_item.col  = col_s2;
		push_item.row  = row_s2;
		push_item.last = last_s2;
	end

	assign push_valid = emit_s2;

endmodule

FILE: hw/rtl/sem_queue.sv
// ----------------------------------------------------------------------------
// sem_queue
// Short queue of gradient items between the front and the back.
// ----------------------------------------------------------------------------
module sem_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push_valid,
	input  sem_pkg::grad_item_t          push_item,
	input  logic                         pop_ready,
	output logic                         pop_valid,
	output sem_pkg::grad_item_t          pop_item,
	output logic [sem_pkg::QLEVEL_W-1:0] level
);
	import sem_pkg::*;

	grad_item_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QLEVEL_W-1:0]   level_q;
	logic                  do_push;
	logic                  do_pop;

	assign pop_valid = (level_q != '0);
	assign pop_item  = entries_q[rd_ptr_q];
	assign level     = level_q;
	assign do_push   = push_valid && (level_q != QLEVEL_W'(QUEUE_DEPTH));
	assign do_pop    = pop_ready && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + QLEVEL_W'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - QLEVEL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: hw/rtl/sem_back.sv
// ----------------------------------------------------------------------------
// sem_back
// Sum of squares, digit-by-digit square root and output register.
// Result is 255 minus the rounded-up root, saturated at 0.
// ----------------------------------------------------------------------------
module sem_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  sem_pkg::grad_item_t pop_item,
	output logic                pop_ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,
	output logic                m_tlast
);
	import sem_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_ROOT,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic signed [10:0] gx_q;
	logic signed [10:0] gy_q;
	logic [10:0]        col_q;
	logic [15:0]        row_q;
	logic               last_q;
	logic [20:0]        rem_q;
	logic [21:0]        root_q;
	logic [20:0]        probe_q;

	logic               out_valid_q;
	logic [7:0]         out_edge_q;
	logic [10:0]        out_col_q;
	logic [15:0]        out_row_q;
	logic               out_last_q;

	logic signed [10:0] mul_in;
	logic signed [21:0] square;
	logic [22:0]        trial;
	logic               fits;
	logic [10:0]        mag;
	logic [7:0]         edge_val;

	assign mul_in = (state_q == ST_SQ_X) ? gx_q : gy_q;
	assign square = mul_in * mul_in;
	assign trial  = 23'(root_q) + 23'(probe_q);
	assign fits   = 23'(rem_q) >= trial;
	assign mag    = 11'(root_q) + 11'(rem_q != 21'd0);
	assign edge_val = (mag >= 11'd255) ? 8'd0 : 8'(11'd255 - mag);

	assign pop_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						gx_q    <= pop_item.gx;
						gy_q    <= pop_item.gy;
						col_q   <= pop_item.col;
						row_q   <= pop_item.row;
						last_q  <= pop_item.last;
						state_q <= ST_SQ_X;
					end
				end
				ST_SQ_X: begin
					rem_q   <= square[20:0];
					state_q <= ST_SQ_Y;
				end
				ST_SQ_Y: begin
					rem_q   <= rem_q + square[20:0];
					root_q  <= '0;
					probe_q <= 21'h100000;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (fits) begin
						rem_q  <= rem_q - trial[20:0];
						root_q <= (root_q >> 1) + 22'(probe_q);
					end else begin
						root_q <= root_q >> 1;
					end
					probe_q <= probe_q >> 2;
					if (probe_q[0]) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_edge_q  <= edge_val;
						out_col_q   <= col_q;
						out_row_q   <= row_q;
						out_last_q  <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_row_q, out_col_q, out_edge_q};
	assign m_tlast  = out_last_q;

endmodule

FILE: hw/rtl/sobel_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// Sobel edge magnitude over a raster stream of red samples.
//
// Usage:
//   s_* channel takes one red sample per item in raster order. For every
//   interior pixel one result leaves on m_*: the inverted gradient magnitude
//   255 - ceil(sqrt(gx*gx + gy*gy)), saturated at 0, with the centre's column
//   and row; m_tlast marks the final interior pixel of the frame. Border
//   pixels give no result.
//   cfg_* writes image_width (index 0) and image_height (index 1); the user
//   must write them only while the core is idle, which the core leaves
//   unchecked itself; cfg_ready is always high.
//   Border items are taken one per cycle. The back end makes one interior
//   result at a time: one square per cycle on the shared multiplier, then
//   11 square-root digit steps. A four-entry gradient queue lets the front
//   take interior items ahead of the back end.
//   Reset restores the 640 x 480 frame size and starts a new frame at row 0,
//   column 0; line store contents are not cleared.
//   When the receiver stalls, the result holds in the output register, the
//   queue fills and s_tready drops for interior pixels.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] red_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] edge_value, [18:8] center_column,
	                               // [34:19] center_row, [39:35] zero
	output logic        m_tlast    // last_of_frame
);
	import sem_pkg::*;

	logic                push_valid;
	grad_item_t          push_item;
	logic                pop_valid;
	logic                pop_ready;
	grad_item_t          pop_item;
	logic [QLEVEL_W-1:0] q_level;

	assign cfg_ready = 1'b1;

	sem_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.pixel     (s_tdata),
		.q_level   (q_level),
		.push_valid(push_valid),
		.push_item (push_item)
	);

	sem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_item (push_item),
		.pop_ready (pop_ready),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.level     (q_level)
	);

	sem_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_item (pop_item),
		.pop_ready(pop_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
